// ===== hw/rtl/abs_pressure_moving_average_unit_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ABS_PRESSURE_MOVING_AVERAGE_UNIT_MACROS_SVH
`define ABS_PRESSURE_MOVING_AVERAGE_UNIT_MACROS_SVH

// Checked only outside reset.
`define APMA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define APMA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/apma_pkg.sv =====
package apma_pkg;

  // field widths
  localparam int ADC_W      = 10;
  localparam int GAIN_W     = 16;
  localparam int OFFSET_W   = 12;
  localparam int MMHG_W     = 12;
  localparam int HPA_W      = 15;
  localparam int AVG_W      = HPA_W - 1;     // average magnitude, at most 8751
  localparam int PROD_W     = ADC_W + GAIN_W;
  localparam int Q_W        = 13;            // sample*gain/10000, at most 6704

  // divide by 10000: (x * ceil(2^40/10000)) >> 40 is exact for x < 2^26
  localparam int GAIN_SHIFT    = 40;
  localparam int GAIN_RECIP_W  = 27;
  localparam logic [GAIN_RECIP_W-1:0] GAIN_RECIP = 27'd109951163;

  // port widths
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 2;

  // register reset values
  localparam logic [GAIN_W-1:0]   GAIN_RST     = 16'd6104;
  localparam logic [OFFSET_W-1:0] OFFSET_RST   = 12'd537;
  localparam logic [MMHG_W-1:0]   MMHG_MAX_RST = 12'd825;
  localparam logic [MMHG_W-1:0]   MMHG_MIN_RST = 12'd450;

  // pipeline: five work stages plus the output register
  localparam int PIPE_DEPTH = 6;

  // range of the hPa field
  localparam logic signed [HPA_W-1:0] HPA_LO = -15'sd2048;
  localparam logic signed [HPA_W-1:0] HPA_HI = 15'sd8751;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN     = 2'd0,
    CFG_OFFSET   = 2'd1,
    CFG_MMHG_MAX = 2'd2,
    CFG_MMHG_MIN = 2'd3
  } cfg_reg_t;

  // one bit per stage: a word moves into that stage on this edge
  typedef struct packed {
    logic so;
    logic s5;
    logic s4;
    logic s3;
    logic s2;
    logic s1;
  } pipe_move_t;

endpackage

// ===== hw/rtl/apma_ram.sv =====
module apma_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 80,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/apma_scale.sv =====
// Stages 1..3: capture sample, sample*gain, then /10000 by reciprocal.
module apma_scale (
  input  logic                                clk,
  input  apma_pkg::pipe_move_t                mv,
  input  logic [apma_pkg::ADC_W-1:0]          adc_sample,
  input  logic [apma_pkg::GAIN_W-1:0]         sensor_gain,
  output logic [apma_pkg::Q_W-1:0]            scaled
);

  localparam int RP_W = apma_pkg::PROD_W + apma_pkg::GAIN_RECIP_W;

  logic [apma_pkg::ADC_W-1:0]  sample_r;
  logic [apma_pkg::PROD_W-1:0] prod_r;
  logic [apma_pkg::Q_W-1:0]    q_r;
  logic [RP_W-1:0]             recip_prod;

  assign recip_prod = RP_W'(prod_r) * RP_W'(apma_pkg::GAIN_RECIP);

  always_ff @(posedge clk) begin
    if (mv.s1) begin
      sample_r <= adc_sample;
    end
    if (mv.s2) begin
      prod_r <= apma_pkg::PROD_W'(sample_r) * apma_pkg::PROD_W'(sensor_gain);
    end
    if (mv.s3) begin
      q_r <= recip_prod[apma_pkg::GAIN_SHIFT +: apma_pkg::Q_W];
    end
  end

  assign scaled = q_r;

endmodule

// ===== hw/rtl/apma_window.sv =====
// Stages 3..4: ring read on entry to stage 3, offset add, sum update and
// ring write-back when the word leaves stage 3.
module apma_window #(
  parameter int WINDOW_LEN = 80,
  localparam int POS_W = $clog2(WINDOW_LEN),
  localparam int SUM_W = apma_pkg::HPA_W + POS_W
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  apma_pkg::pipe_move_t              mv,
  input  logic [apma_pkg::Q_W-1:0]          scaled,
  input  logic [apma_pkg::OFFSET_W-1:0]     pressure_offset,
  output logic [apma_pkg::HPA_W-1:0]        hpa,
  output logic [SUM_W-1:0]                  window_sum
);

  localparam int HPA_W = apma_pkg::HPA_W;

  logic [POS_W-1:0]      wp_r;
  logic [POS_W-1:0]      pos3_r;
  logic                  old_vld_r;
  logic [WINDOW_LEN-1:0] ring_vld_r;
  logic [HPA_W-1:0]      ring_rdata;
  logic [HPA_W-1:0]      old_hpa;
  logic [HPA_W-1:0]      hpa_s3;
  logic [SUM_W-1:0]      sum_r;
  logic [SUM_W-1:0]      sum_nxt;
  logic [HPA_W-1:0]      hpa_r;

  apma_ram #(
    .WIDTH (HPA_W),
    .DEPTH (WINDOW_LEN)
  ) u_ring (
    .clk   (clk),
    .we    (mv.s4),
    .waddr (pos3_r),
    .wdata (hpa_s3),
    .re    (mv.s3),
    .raddr (wp_r),
    .rdata (ring_rdata)
  );

  // never-written entries read as zero
  assign old_hpa = old_vld_r ? ring_rdata : '0;

  assign hpa_s3 = HPA_W'(scaled)
                + {{(HPA_W - apma_pkg::OFFSET_W){pressure_offset[apma_pkg::OFFSET_W-1]}},
                   pressure_offset};

  assign sum_nxt = sum_r
                 - {{(SUM_W - HPA_W){old_hpa[HPA_W-1]}}, old_hpa}
                 + {{(SUM_W - HPA_W){hpa_s3[HPA_W-1]}}, hpa_s3};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      ring_vld_r <= '0;
      sum_r      <= '0;
    end else begin
      if (mv.s3) begin
        wp_r <= (wp_r == POS_W'(WINDOW_LEN - 1)) ? '0 : wp_r + POS_W'(1);
      end
      if (mv.s4) begin
        ring_vld_r[pos3_r] <= 1'b1;
        sum_r              <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mv.s3) begin
      pos3_r    <= wp_r;
      old_vld_r <= ring_vld_r[wp_r];
    end
    if (mv.s4) begin
      hpa_r <= hpa_s3;
    end
  end

  assign hpa        = hpa_r;
  assign window_sum = sum_r;

endmodule

// ===== hw/rtl/apma_convert.sv =====
// Stage 5: |sum| / WINDOW_LEN by reciprocal. Output stage: *7.5 and clamp.
module apma_convert #(
  parameter int WINDOW_LEN = 80,
  localparam int WIN_BITS = $clog2(WINDOW_LEN),
  localparam int SUM_W    = apma_pkg::HPA_W + WIN_BITS
) (
  input  logic                            clk,
  input  apma_pkg::pipe_move_t            mv,
  input  logic [apma_pkg::HPA_W-1:0]      hpa,
  input  logic [SUM_W-1:0]                window_sum,
  input  logic [apma_pkg::MMHG_W-1:0]     mmhg_max,
  input  logic [apma_pkg::MMHG_W-1:0]     mmhg_min,
  output logic [apma_pkg::HPA_W-1:0]      pressure_hpa,
  output logic [apma_pkg::MMHG_W-1:0]     pressure_mmhg
);

  localparam int AVG_W   = apma_pkg::AVG_W;
  localparam int MMHG_W  = apma_pkg::MMHG_W;
  // (x * ceil(2^SH/W)) >> SH is exact for x < 2^SUM_W since W <= 2^WIN_BITS
  localparam int AVG_SHIFT = SUM_W + WIN_BITS;
  localparam int RECIP_W   = SUM_W + 1;
  localparam longint unsigned AVG_RECIP_L =
    ((64'd1 << AVG_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
  localparam logic [RECIP_W-1:0] AVG_RECIP = RECIP_W'(AVG_RECIP_L);
  localparam int AP_W = SUM_W + RECIP_W;
  localparam int X_W  = AVG_W + 4;       // avg * 15
  localparam int CMP_W = X_W;

  logic [SUM_W-1:0]         sum_mag;
  logic [AP_W-1:0]          avg_prod;
  logic [AVG_W-1:0]         avg_mag_r;
  logic                     neg_r;
  logic [apma_pkg::HPA_W-1:0] hpa5_r;

  logic [X_W-1:0]           x15;
  logic [X_W-2:0]           half;
  logic signed [CMP_W-1:0]  mmhg_s;
  logic [MMHG_W-1:0]        mmhg_nxt;

  logic [apma_pkg::HPA_W-1:0] out_hpa_r;
  logic [MMHG_W-1:0]          out_mmhg_r;

  assign sum_mag  = window_sum[SUM_W-1] ? (~window_sum + SUM_W'(1)) : window_sum;
  assign avg_prod = AP_W'(sum_mag) * AP_W'(AVG_RECIP);

  // avg*75/10 == avg*15/2, truncated toward zero on the magnitude
  assign x15  = {avg_mag_r, 4'b0000} - X_W'(avg_mag_r);
  assign half = x15[X_W-1:1];

  always_comb begin
    mmhg_s = neg_r ? -$signed({1'b0, half}) : $signed({1'b0, half});
    priority if (mmhg_s >= $signed({{(CMP_W - MMHG_W){1'b0}}, mmhg_max})) begin
      mmhg_nxt = mmhg_max;
    end else if (mmhg_s <= $signed({{(CMP_W - MMHG_W){1'b0}}, mmhg_min})) begin
      mmhg_nxt = mmhg_min;
    end else begin
      mmhg_nxt = half[MMHG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mv.s5) begin
      avg_mag_r <= avg_prod[AVG_SHIFT +: AVG_W];
      neg_r     <= window_sum[SUM_W-1];
      hpa5_r    <= hpa;
    end
    if (mv.so) begin
      out_hpa_r  <= hpa5_r;
      out_mmhg_r <= mmhg_nxt;
    end
  end

  assign pressure_hpa  = out_hpa_r;
  assign pressure_mmhg = out_mmhg_r;

endmodule

// ===== hw/rtl/abs_pressure_moving_average_unit.sv =====
// Absolute pressure scaler with moving-average filter. Each input word is one
// 10-bit converter sample; each gives exactly one result word holding the
// unfiltered pressure in hPa (sample*gain/10000 + offset) and the average of
// the last WINDOW_LEN hPa values converted to mmHg (*7.5, truncated toward
// zero) and clamped (max checked first, so it wins if the limits cross).
// The ring starts cleared, so the first WINDOW_LEN averages still divide by
// WINDOW_LEN. Throughput is one word per clock while out_tready does not stall
// the output; the six-register pipeline is sample, gain product, /10000, ring
// update and sum, /WINDOW_LEN, and mmHg and clamp, in that order. The
// ring lives in a RAM read as a word enters stage 3 and written as it leaves,
// so no ring access ever waits; an entry's valid flop (cleared by reset) makes
// unwritten entries read as zero, so there is no clearing pass after reset.
// Stalls ripple back stage by stage: a waiting result does not block input
// while an earlier stage has a bubble. Write configuration only when idle.
module abs_pressure_moving_average_unit #(
  parameter int WINDOW_LEN = 80    // 2..256
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input stream
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [apma_pkg::IN_TDATA_W-1:0]       in_tdata,   // [9:0] adc_sample
  // result stream
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [apma_pkg::OUT_TDATA_W-1:0]      out_tdata,  // [14:0] pressure_hpa,
                                                            // [26:15] pressure_mmhg
  // configuration writes
  input  logic                                  cfg_wr_en,
  input  logic [apma_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [apma_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int NST   = apma_pkg::PIPE_DEPTH;
  localparam int SUM_W = apma_pkg::HPA_W + $clog2(WINDOW_LEN);

  // config registers
  logic [apma_pkg::GAIN_W-1:0]   gain_r;
  logic [apma_pkg::OFFSET_W-1:0] offset_r;
  logic [apma_pkg::MMHG_W-1:0]   max_r;
  logic [apma_pkg::MMHG_W-1:0]   min_r;

  // pipeline control
  logic [NST-1:0]       vld_r;
  logic [NST-1:0]       vld_nxt;
  logic [NST-1:0]       ld;       // stage k may load this edge
  logic [NST-1:0]       mv_vec;   // a word moves into stage k
  apma_pkg::pipe_move_t mv;

  // datapath
  logic [apma_pkg::Q_W-1:0]    scaled;
  logic [apma_pkg::HPA_W-1:0]  hpa4;
  logic [SUM_W-1:0]            window_sum;
  logic [apma_pkg::HPA_W-1:0]  pressure_hpa;
  logic [apma_pkg::MMHG_W-1:0] pressure_mmhg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= apma_pkg::GAIN_RST;
      offset_r <= apma_pkg::OFFSET_RST;
      max_r    <= apma_pkg::MMHG_MAX_RST;
      min_r    <= apma_pkg::MMHG_MIN_RST;
    end else if (cfg_wr_en) begin
      unique case (apma_pkg::cfg_reg_t'(cfg_index))
        apma_pkg::CFG_GAIN:     gain_r   <= cfg_wdata[apma_pkg::GAIN_W-1:0];
        apma_pkg::CFG_OFFSET:   offset_r <= cfg_wdata[apma_pkg::OFFSET_W-1:0];
        apma_pkg::CFG_MMHG_MAX: max_r    <= cfg_wdata[apma_pkg::MMHG_W-1:0];
        apma_pkg::CFG_MMHG_MIN: min_r    <= cfg_wdata[apma_pkg::MMHG_W-1:0];
      endcase
    end
  end

  // stage k loads when empty or when its word moves on
  always_comb begin
    ld[NST-1] = !vld_r[NST-1] || out_tready;
    for (int k = NST - 2; k >= 0; k--) begin
      ld[k] = !vld_r[k] || ld[k+1];
    end
    mv_vec[0] = in_tvalid && ld[0];
    for (int k = 1; k < NST; k++) begin
      mv_vec[k] = vld_r[k-1] && ld[k];
    end
    for (int k = 0; k < NST - 1; k++) begin
      vld_nxt[k] = mv_vec[k] || (vld_r[k] && !ld[k+1]);
    end
    vld_nxt[NST-1] = mv_vec[NST-1] || (vld_r[NST-1] && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign mv        = apma_pkg::pipe_move_t'(mv_vec);
  assign in_tready = ld[0];

  apma_scale u_scale (
    .clk         (clk),
    .mv          (mv),
    .adc_sample  (in_tdata[apma_pkg::ADC_W-1:0]),
    .sensor_gain (gain_r),
    .scaled      (scaled)
  );

  apma_window #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_window (
    .clk             (clk),
    .rst_n           (rst_n),
    .mv              (mv),
    .scaled          (scaled),
    .pressure_offset (offset_r),
    .hpa             (hpa4),
    .window_sum      (window_sum)
  );

  apma_convert #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_convert (
    .clk           (clk),
    .mv            (mv),
    .hpa           (hpa4),
    .window_sum    (window_sum),
    .mmhg_max      (max_r),
    .mmhg_min      (min_r),
    .pressure_hpa  (pressure_hpa),
    .pressure_mmhg (pressure_mmhg)
  );

  assign out_tvalid = vld_r[NST-1];
  assign out_tdata  = {
    {(apma_pkg::OUT_TDATA_W - apma_pkg::HPA_W - apma_pkg::MMHG_W){1'b0}},
    pressure_mmhg,
    pressure_hpa
  };

endmodule

// ===== hw/rtl/apma_checker.sv =====
`include "abs_pressure_moving_average_unit_macros.svh"

module apma_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [apma_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  // words accepted but not yet delivered
  logic [3:0] pend_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 4'(in_acc) - 4'(out_acc);
    end
  end

  `APMA_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")
  `APMA_ASSERT_ALWAYS(a_rst_clear, !rst_n |=> !out_tvalid, "result valid right after reset")
  `APMA_ASSERT(a_no_orphan, out_tvalid |-> pend_r != 4'd0 && pend_r <= 4'(apma_pkg::PIPE_DEPTH), "result count does not match accepted words")
  `APMA_ASSERT(a_hpa_range, out_tvalid |-> $signed(out_tdata[14:0]) >= apma_pkg::HPA_LO && $signed(out_tdata[14:0]) <= apma_pkg::HPA_HI, "hPa field out of range")

endmodule

bind abs_pressure_moving_average_unit apma_checker u_apma_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== dv/testbench.sv =====
// Pressure scaler / moving-average filter testbench.
// A directed table runs first: reset values, field extremes, zero and full
// gain, negative averages, crossed clamp limits. Random phases follow, each
// with its own register setting and sample mix. Every result word is checked against
// an in-bench model of the scaler, the 80-entry ring and the clamp, or the typed row's word.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_LEN    = 80;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 10;
  localparam int PHASE_WORDS = 130;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  // one line of the directed table
  typedef struct {
    row_kind_t          kind;
    apma_pkg::cfg_reg_t sel;     // register, ROW_WRITE only
    logic [15:0]        value;   // sample or register value
    bit                 typed;   // expected word given below
    logic signed [14:0] hpa;
    logic [11:0]        mmhg;
  } stim_row_t;

  typedef struct {
    logic signed [14:0] hpa;
    logic [11:0]        mmhg;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                             in_tvalid;
  logic                             in_tready;
  logic [apma_pkg::IN_TDATA_W-1:0]  in_tdata;    // [9:0] adc_sample
  logic                             out_tvalid;
  logic                             out_tready = 1'b1;
  logic [apma_pkg::OUT_TDATA_W-1:0] out_tdata;   // [14:0] pressure_hpa, [26:15] pressure_mmhg
  logic                             cfg_wr_en;
  apma_pkg::cfg_reg_t               cfg_index;
  logic [apma_pkg::CFG_DATA_W-1:0]  cfg_wdata;

  // model state: registers, ring, running sum
  logic [15:0]        gain_q;
  logic signed [11:0] offset_q;
  logic [11:0]        max_q;
  logic [11:0]        min_q;
  logic signed [14:0] hpa_ring [RING_LEN];
  int                 ring_pos;
  int                 ring_sum;

  reading_t pending_readings [$];

  int mismatches;
  int words_sent;
  int words_checked;
  int writes_done;
  int at_max;
  int at_min;
  int mid_band;
  int cycle_count;

  // per-phase idling, percent chance of a burst before a word
  int  send_gap_pct;
  int  stall_pct;
  bit  quiet_tail;

  stim_row_t directed_rows [26];

  abs_pressure_moving_average_unit #(
    .WINDOW_LEN (RING_LEN)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  // hard stop
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still pending", cycle_count,
               pending_readings.size());
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Scale one sample, push it through the ring and return the word the
  // block should give: raw hPa plus the clamped mmHg of the window average.
  function automatic reading_t predict_reading(input logic [9:0] adc);
    int       hpa;
    int       avg;
    int       mm;
    reading_t r;
    hpa = (int'(adc) * int'(gain_q)) / 10000 + int'(offset_q);
    ring_sum = ring_sum - int'(hpa_ring[ring_pos]) + hpa;
    hpa_ring[ring_pos] = hpa[14:0];
    ring_pos = (ring_pos + 1) % RING_LEN;
    avg = ring_sum / RING_LEN;      // truncates toward zero
    mm = (avg * 75) / 10;
    // max is tested first, so it wins when the limits cross
    if (mm >= int'(max_q))
      mm = int'(max_q);
    else if (mm <= int'(min_q))
      mm = int'(min_q);
    r.hpa  = hpa[14:0];
    r.mmhg = mm[11:0];
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %0s at result %0d: got %0d, want %0d", $realtime, what,
             words_checked, got, want);
    mismatches++;
  endtask

  // one word out per accepted input; check it against the oldest prediction
  always @(posedge clk) begin
    reading_t           want;
    logic signed [14:0] got_hpa;
    logic [11:0]        got_mm;
    if (rst_n && out_tvalid && out_tready) begin
      got_hpa = out_tdata[14:0];
      got_mm  = out_tdata[26:15];
      if (pending_readings.size() == 0) begin
        flag_mismatch("unexpected word, hPa", int'(got_hpa), 0);
      end else begin
        want = pending_readings.pop_front();
        if (got_hpa !== want.hpa)
          flag_mismatch("pressure_hpa", int'(got_hpa), int'(want.hpa));
        if (got_mm !== want.mmhg)
          flag_mismatch("pressure_mmhg", int'(got_mm), int'(want.mmhg));
        if (want.mmhg == max_q)
          at_max++;
        else if (want.mmhg == min_q)
          at_min++;
        else
          mid_band++;
      end
      words_checked++;
    end
  end

  // result side backpressure: random stall bursts, none in the tail
  always @(posedge clk) begin
    int stall_left;
    if (!rst_n || quiet_tail) begin
      stall_left = 0;
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(1, 7) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Hold a word on the input until taken, then predict it. A typed row
  // supplies its own expected word; the model still advances.
  task automatic send_sample(input logic [9:0] adc, input bit typed, input reading_t typed_r);
    reading_t r;
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, adc};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = predict_reading(adc);
    pending_readings.push_back(typed ? typed_r : r);
    words_sent++;
  endtask

  task automatic maybe_gap();
    if ($urandom_range(0, 99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // stop sending until every predicted word is back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_readings.size() != 0);
  endtask

  // enable stays high across back-to-back writes; close_writes drops it
  task automatic write_reg(input apma_pkg::cfg_reg_t sel, input logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= val;
    @(posedge clk);
    case (sel)
      apma_pkg::CFG_GAIN:     gain_q   = val;
      apma_pkg::CFG_OFFSET:   offset_q = val[11:0];
      apma_pkg::CFG_MMHG_MAX: max_q    = val[11:0];
      apma_pkg::CFG_MMHG_MIN: min_q    = val[11:0];
    endcase
    writes_done++;
  endtask

  task automatic close_writes();
    cfg_wr_en <= 1'b0;
  endtask

  // random register setting for one phase; last phase goes back to reset values
  task automatic program_phase(input int p);
    int          off;
    int          lo;
    logic [15:0] g;
    logic [11:0] hi_lim;
    logic [11:0] lo_lim;
    case ($urandom_range(0, 5))
      0:       g = 16'd0;
      1:       g = 16'hFFFF;
      2:       g = 16'd6104;
      3:       g = 16'($urandom_range(0, 4000));
      default: g = 16'($urandom_range(0, 65535));
    endcase
    case ($urandom_range(0, 4))
      0:       off = -2048;
      1:       off = 2047;
      2:       off = $urandom_range(0, 600) - 400;   // offset from -400 to 200
      default: off = $urandom_range(0, 4095) - 2048;
    endcase
    case ($urandom_range(0, 4))
      0: begin
        hi_lim = 12'hFFF;
        lo_lim = 12'h000;
      end
      1: begin                                    // crossed
        hi_lim = 12'($urandom_range(0, 2000));
        lo_lim = 12'($urandom_range(2001, 4095));
      end
      2: begin
        hi_lim = 12'($urandom_range(0, 4095));
        lo_lim = hi_lim;
      end
      default: begin
        lo = $urandom_range(0, 2000);
        lo_lim = 12'(lo);
        hi_lim = 12'($urandom_range(lo, 4095));
      end
    endcase
    if (p == PHASES - 1) begin
      g      = apma_pkg::GAIN_RST;
      off    = 537;
      hi_lim = apma_pkg::MMHG_MAX_RST;
      lo_lim = apma_pkg::MMHG_MIN_RST;
    end
    write_reg(apma_pkg::CFG_GAIN, g);
    write_reg(apma_pkg::CFG_OFFSET, {4'b0, off[11:0]});
    write_reg(apma_pkg::CFG_MMHG_MAX, {4'b0, hi_lim});
    write_reg(apma_pkg::CFG_MMHG_MIN, {4'b0, lo_lim});
    close_writes();
  endtask

  initial begin
    reading_t    typed_r;
    stim_row_t   row;
    logic [9:0]  adc;
    int          base;
    int          v;
    row_kind_t   prev_kind;

    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= apma_pkg::CFG_GAIN;
    cfg_wdata <= '0;
    rst_n     <= 1'b0;

    gain_q   = apma_pkg::GAIN_RST;
    offset_q = apma_pkg::OFFSET_RST;
    max_q    = apma_pkg::MMHG_MAX_RST;
    min_q    = apma_pkg::MMHG_MIN_RST;
    foreach (hpa_ring[i]) hpa_ring[i] = '0;
    ring_pos = 0;
    ring_sum = 0;
    send_gap_pct = 25;
    stall_pct    = 25;
    quiet_tail   = 1'b0;

    // reset values first; then gain 0 with offset -2048 drives the ring
    // negative (min/max pinned to 0 makes those words obvious); crossed
    // limits with a negative and then a positive average; full gain and
    // offset give the top of the hPa range
    directed_rows = '{
      '{ROW_SAMPLE, apma_pkg::CFG_GAIN,     16'd0,    1'b1,  15'sd537,  12'd450},
      '{ROW_SAMPLE, apma_pkg::CFG_GAIN,     16'd1023, 1'b1,  15'sd1161, 12'd450},
      '{ROW_SAMPLE, apma_pkg::CFG_GAIN,     16'd512,  1'b0,  15'sd0,    12'd0},
      '{ROW_SAMPLE, apma_pkg::CFG_GAIN,     16'd341,  1'b0,  15'sd0,    12'd0},
      '{ROW_SAMPLE, apma_pkg::CFG_GAIN,     16'd682,  1'b0,  15'sd0,    12'd0},
      '{ROW_WRITE,  apma_pkg::CFG_GAIN,     16'd0,    1'b0,  15'sd0,    12'd0},
      '{ROW_WRITE,  apma_pkg::CFG_OFFSET,   16'h0800, 1'b0,  15'sd0,    12'd0},
      '{ROW_WRITE,  apma_pkg::CFG_MMHG_MAX, 16'd0,    1'b0,  15'sd0,    12'd0},
      '{ROW_WRITE,  apma_pkg::CFG_MMHG_MIN, 16'd0,    1'b0,  15'sd0,    12'd0},
      '{ROW_SAMPLE, apma_pkg::CFG_GAIN,     16'd1023, 1'b1, -15'sd2048, 12'd0},
      '{ROW_SAMPLE, apma_pkg::CFG_GAIN,     16'd0,    1'b1, -15'sd2048, 12'd0},
      '{ROW_WRITE,  apma_pkg::CFG_MMHG_MAX, 16'd100,  1'b0,  15'sd0,    12'd0},
      '{ROW_WRITE,  apma_pkg::CFG_MMHG_MIN, 16'd3000, 1'b0,  15'sd0,    12'd0},
      '{ROW_SAMPLE, apma_pkg::CFG_GAIN,     16'd341,  1'b0,  15'sd0,    12'd0},
      '{ROW_SAMPLE, apma_pkg::CFG_GAIN,     16'd682,  1'b0,  15'sd0,    12'd0},
      '{ROW_WRITE,  apma_pkg::CFG_GAIN,     16'hFFFF, 1'b0,  15'sd0,    12'd0},
      '{ROW_WRITE,  apma_pkg::CFG_OFFSET,   16'h07FF, 1'b0,  15'sd0,    12'd0},
      '{ROW_SAMPLE, apma_pkg::CFG_GAIN,     16'd1023, 1'b0,  15'sd0,    12'd0},
      '{ROW_SAMPLE, apma_pkg::CFG_GAIN,     16'd1023, 1'b0,  15'sd0,    12'd0},
      '{ROW_SAMPLE, apma_pkg::CFG_GAIN,     16'd0,    1'b0,  15'sd0,    12'd0},
      '{ROW_WRITE,  apma_pkg::CFG_MMHG_MAX, 16'd0,    1'b0,  15'sd0,    12'd0},
      '{ROW_WRITE,  apma_pkg::CFG_MMHG_MIN, 16'd0,    1'b0,  15'sd0,    12'd0},
      '{ROW_SAMPLE, apma_pkg::CFG_GAIN,     16'd1023, 1'b1,  15'sd8751, 12'd0},
      '{ROW_WRITE,  apma_pkg::CFG_MMHG_MAX, 16'd4095, 1'b0,  15'sd0,    12'd0},
      '{ROW_SAMPLE, apma_pkg::CFG_GAIN,     16'd512,  1'b0,  15'sd0,    12'd0},
      '{ROW_SAMPLE, apma_pkg::CFG_GAIN,     16'd0,    1'b0,  15'sd0,    12'd0}
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    prev_kind = ROW_SAMPLE;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) begin
        if (prev_kind == ROW_SAMPLE)
          wait_drained();
        write_reg(row.sel, row.value);
      end else begin
        if (prev_kind == ROW_WRITE)
          close_writes();
        maybe_gap();
        typed_r.hpa  = row.hpa;
        typed_r.mmhg = row.mmhg;
        send_sample(row.value[9:0], row.typed, typed_r);
      end
      prev_kind = row.kind;
    end

    // random phases: new registers each time, half the samples hover around a
    // phase level so the average settles, with full-range and rail noise
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      program_phase(p);
      if (p == PHASES - 1) begin
        send_gap_pct = 0;
        stall_pct    = 0;
        quiet_tail   = 1'b1;
      end else begin
        send_gap_pct = (p % 3) * 25;
        stall_pct    = ((p + 1) % 3) * 25;
      end
      base = $urandom_range(0, 1023);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        case ($urandom_range(0, 9))
          0:          adc = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
          1, 2, 3, 4: adc = 10'($urandom_range(0, 1023));
          default: begin
            v = base + $urandom_range(0, 30) - 15;
            if (v < 0) v = 0;
            if (v > 1023) v = 1023;
            adc = 10'(v);
          end
        endcase
        maybe_gap();
        send_sample(adc, 1'b0, typed_r);
        // sender holds off until the pipe is empty, mid-phase
        if ((p == 3 && k == 60) || $urandom_range(0, 199) == 0)
          wait_drained();
      end
    end

    wait_drained();
    repeat (apma_pkg::PIPE_DEPTH + 4) @(posedge clk);

    $display("testbench: %0d samples, %0d results checked, %0d register writes over %0d phases",
             words_sent, words_checked, writes_done, PHASES + 1);
    $display("testbench: mmHg at upper clamp %0d, at lower clamp %0d, inside band %0d",
             at_max, at_min, mid_band);
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
